@@ sv/vrc_pkg.sv @@
// Shared widths, constants and types of the value to RGB colormap.
package vrc_pkg;

    localparam int FRAC_BITS = 16;                // fraction bits of the normalized value
    localparam int DATA_W    = 32;                // sample and bound width
    localparam int NUM_W     = DATA_W + 1;        // exact difference width
    localparam int REM_W     = NUM_W + 1;         // divider remainder width
    localparam int Q_W       = FRAC_BITS + 1;     // normalized value, 0 to 1.5
    localparam int PROD_W    = Q_W + 10;          // ramp product width

    localparam logic [Q_W-1:0] C_E1  = Q_W'(1 << (FRAC_BITS - 3));
    localparam logic [Q_W-1:0] C_E3  = Q_W'(3 << (FRAC_BITS - 3));
    localparam logic [Q_W-1:0] C_E5  = Q_W'(5 << (FRAC_BITS - 3));
    localparam logic [Q_W-1:0] C_E7  = Q_W'(7 << (FRAC_BITS - 3));
    localparam logic [Q_W-1:0] C_E8  = Q_W'(8 << (FRAC_BITS - 3));
    localparam logic [Q_W-1:0] C_E9  = Q_W'(9 << (FRAC_BITS - 3));
    localparam logic [Q_W-1:0] C_E10 = Q_W'(10 << (FRAC_BITS - 3));
    localparam logic [Q_W-1:0] C_E12 = Q_W'(12 << (FRAC_BITS - 3));

    localparam logic [9:0] SLOPE      = 10'd1020;
    localparam logic [7:0] LVL_ZERO   = 8'd0;
    localparam logic [7:0] LVL_FULL   = 8'd255;
    localparam logic [7:0] LVL_DARK   = 8'd128;

    localparam logic [DATA_W-1:0] RST_LOW  = DATA_W'(0);
    localparam logic [DATA_W-1:0] RST_HIGH = DATA_W'(65536);

    typedef enum logic [1:0] {
        CFG_LOW_BOUND  = 2'd0,
        CFG_HIGH_BOUND = 2'd1,
        CFG_PAST_MAX   = 2'd2
    } t_cfg_idx;

    // One color channel before the slope multiply.
    typedef struct packed {
        logic           is_ramp;
        logic [7:0]     level;
        logic [Q_W-1:0] delta;
    } t_chan;

endpackage

@@ sv/value_to_rgb_colormap.sv @@
// Value to RGB jet colormap: normalize, restoring divide, clamp, segment select, ramp.
// Throughput: one word per cycle; one quotient bit per pipeline stage, 17 divider stages.
// A stall holds only the full stages ahead of the first empty one, so bubbles are filled.
// Reset (synchronous, active low) empties the pipeline and sets the bounds to 0 and 1.0
// and the over-range mode to the magenta-to-white extension.
module value_to_rgb_colormap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [vrc_pkg::DATA_W-1:0]  i_sample_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_red,
    output logic [7:0]                  o_green,
    output logic [7:0]                  o_blue,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [vrc_pkg::DATA_W-1:0]  i_cfg_data
);
    import vrc_pkg::*;

    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_D0  = 2;
    localparam int ST_CL  = ST_D0 + Q_W + 1;
    localparam int ST_SEG = ST_CL + 1;
    localparam int ST_OUT = ST_SEG + 1;
    localparam int NST    = ST_OUT + 1;

    // Configuration registers.
    logic [DATA_W-1:0] r_low;
    logic [DATA_W-1:0] r_high;
    logic              r_past;

    // Handshake of the stage chain.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_rdy;
    logic [NST-1:0] w_vin;

    // Stage A: differences.
    logic [NUM_W-1:0] r_a_num;
    logic [NUM_W-1:0] r_a_den;

    // Stage B: magnitudes and special cases.
    logic [NUM_W-1:0] r_b_an;
    logic [NUM_W-1:0] r_b_ad;
    logic             r_b_sat;
    logic             w_num_neg;
    logic             w_den_neg;
    logic             w_den_zero;
    logic             w_zero_c;
    logic             w_sat_c;
    logic [NUM_W-1:0] w_an;
    logic [NUM_W-1:0] w_ad;

    // Divider stages; entry 0 is the divider input.
    logic [REM_W-1:0] r_rem [0:Q_W];
    logic [NUM_W-1:0] r_ad  [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic             r_sat [0:Q_W];

    // Clamp, segment and output stages.
    logic [Q_W-1:0]    r_c;
    t_chan             r_red_ch;
    t_chan             r_grn_ch;
    t_chan             r_blu_ch;
    t_chan             n_red_ch;
    t_chan             n_grn_ch;
    t_chan             n_blu_ch;
    logic [PROD_W-1:0] w_red_prod;
    logic [PROD_W-1:0] w_grn_prod;
    logic [PROD_W-1:0] w_blu_prod;
    logic [7:0]        r_red;
    logic [7:0]        r_green;
    logic [7:0]        r_blue;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= RST_LOW;
            r_high <= RST_HIGH;
            r_past <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOW_BOUND:  r_low  <= i_cfg_data;
                CFG_HIGH_BOUND: r_high <= i_cfg_data;
                CFG_PAST_MAX:   r_past <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A stage takes a new word when it is empty or its successor moves on.
    assign w_vin = {r_vld[NST-2:0], i_in_valid};

    always_comb begin
        w_rdy[NST-1] = !r_vld[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    assign o_in_ready = w_rdy[ST_A];

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_A]) begin
            r_a_num <= {i_sample_value[DATA_W-1], i_sample_value} - {r_low[DATA_W-1], r_low};
            r_a_den <= {r_high[DATA_W-1], r_high} - {r_low[DATA_W-1], r_low};
        end
    end

    // A zero range saturates when the sample is at or above the low bound.
    always_comb begin
        w_num_neg  = r_a_num[NUM_W-1];
        w_den_neg  = r_a_den[NUM_W-1];
        w_den_zero = (r_a_den == '0);
        w_an       = w_num_neg ? (NUM_W'(0) - r_a_num) : r_a_num;
        w_ad       = w_den_neg ? (NUM_W'(0) - r_a_den) : r_a_den;
        w_sat_c    = w_den_zero && !w_num_neg;
        w_zero_c   = w_den_zero ? w_num_neg
                                : ((r_a_num == '0) || (w_num_neg != w_den_neg));
    end

    // Forced cases divide zero by one so the divider stays harmless.
    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_B]) begin
            r_b_an  <= (w_zero_c || w_sat_c) ? NUM_W'(0) : w_an;
            r_b_ad  <= (w_zero_c || w_sat_c) ? NUM_W'(1) : w_ad;
            r_b_sat <= w_sat_c;
        end
    end

    // A quotient of two or more saturates; below that 17 bits hold it.
    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_D0]) begin
            r_rem[0] <= {1'b0, r_b_an};
            r_ad[0]  <= r_b_ad;
            r_q[0]   <= '0;
            r_sat[0] <= r_b_sat || ({1'b0, r_b_an} >= {r_b_ad, 1'b0});
        end
    end

    // Restoring division, one quotient bit per stage; the remainder stays below
    // twice the divisor, so the shifted remainder fits.
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic             w_ge;
        logic [REM_W-1:0] w_dif;

        assign w_ge  = (r_rem[j] >= {1'b0, r_ad[j]});
        assign w_dif = w_ge ? (r_rem[j] - {1'b0, r_ad[j]}) : r_rem[j];

        always_ff @(posedge i_clk) begin
            if (w_rdy[ST_D0+1+j]) begin
                r_rem[j+1] <= {w_dif[REM_W-2:0], 1'b0};
                r_ad[j+1]  <= r_ad[j];
                r_q[j+1]   <= {r_q[j][Q_W-2:0], w_ge};
                r_sat[j+1] <= r_sat[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_CL]) begin
            r_c <= (r_sat[Q_W] || (r_q[Q_W] > C_E12)) ? C_E12 : r_q[Q_W];
        end
    end

    // Segment select of the jet ramp and its over-range extension.
    always_comb begin
        n_red_ch = '{is_ramp: 1'b0, level: LVL_ZERO, delta: '0};
        n_grn_ch = '{is_ramp: 1'b0, level: LVL_ZERO, delta: '0};
        n_blu_ch = '{is_ramp: 1'b0, level: LVL_ZERO, delta: '0};
        if (r_c < C_E1) begin
            n_blu_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: r_c + C_E1};
        end else if (r_c < C_E3) begin
            n_grn_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: r_c - C_E1};
            n_blu_ch.level = LVL_FULL;
        end else if (r_c < C_E5) begin
            n_red_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: r_c - C_E3};
            n_grn_ch.level = LVL_FULL;
            n_blu_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: C_E5 - r_c};
        end else if (r_c < C_E7) begin
            n_red_ch.level = LVL_FULL;
            n_grn_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: C_E7 - r_c};
        end else if (r_c < C_E8) begin
            n_red_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: C_E9 - r_c};
        end else if (r_past) begin
            if (r_c < C_E9) begin
                n_red_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: r_c - C_E7};
                n_blu_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: r_c - C_E8};
            end else if (r_c < C_E10) begin
                n_red_ch.level = LVL_FULL;
                n_blu_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: r_c - C_E8};
            end else if (r_c < C_E12) begin
                n_red_ch.level = LVL_FULL;
                n_grn_ch = '{is_ramp: 1'b1, level: LVL_ZERO, delta: r_c - C_E10};
                n_blu_ch.level = LVL_FULL;
            end else begin
                n_red_ch.level = LVL_FULL;
                n_grn_ch.level = LVL_FULL;
                n_blu_ch.level = LVL_FULL;
            end
        end else begin
            n_red_ch.level = LVL_DARK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_SEG]) begin
            r_red_ch <= n_red_ch;
            r_grn_ch <= n_grn_ch;
            r_blu_ch <= n_blu_ch;
        end
    end

    // The slope of 1020 per unit, truncated to the integer part.
    assign w_red_prod = PROD_W'(r_red_ch.delta) * PROD_W'(SLOPE);
    assign w_grn_prod = PROD_W'(r_grn_ch.delta) * PROD_W'(SLOPE);
    assign w_blu_prod = PROD_W'(r_blu_ch.delta) * PROD_W'(SLOPE);

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_OUT]) begin
            r_red   <= r_red_ch.is_ramp ? w_red_prod[FRAC_BITS+7:FRAC_BITS] : r_red_ch.level;
            r_green <= r_grn_ch.is_ramp ? w_grn_prod[FRAC_BITS+7:FRAC_BITS] : r_grn_ch.level;
            r_blue  <= r_blu_ch.is_ramp ? w_blu_prod[FRAC_BITS+7:FRAC_BITS] : r_blu_ch.level;
        end
    end

    assign o_out_valid = r_vld[ST_OUT];
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

endmodule

@@ sv/vrc_check.sv @@
// Port-level assertions of the value to RGB colormap and their binding.
module vrc_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [7:0]                  o_red,
    input  logic [7:0]                  o_green,
    input  logic [7:0]                  o_blue
);
    import vrc_pkg::*;

    // The pipeline is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present right after reset");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable({o_red, o_green, o_blue}))
        else $error("stalled result word changed");

    // With no red, the color lies in the blue or cyan part of the ramp, or at the very
    // start of the green part where the red ramp still truncates to zero.
    a_no_red_blue_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_red == LVL_ZERO) |->
            (o_green == LVL_ZERO) || (o_blue == LVL_FULL) || (o_green == LVL_FULL))
        else $error("red off outside the blue and cyan segments");

    // A result can only leave while the input side is not held by a full pipe forever:
    // whenever the output is free, the input side is ready.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while the output drains");

endmodule

bind value_to_rgb_colormap vrc_check u_vrc_check (.*);

@@ dv/value_to_rgb_colormap_tb.sv @@
// Self-checking testbench for the value to RGB jet colormap with over-range extension.
`timescale 1ns / 1ps

module value_to_rgb_colormap_tb;
    import vrc_pkg::*;

    localparam int LATENCY     = 22;
    localparam int DRAIN_LIMIT = 5000;
    localparam int PHASE_ITEMS = 125;
    localparam int NUM_PHASES  = 10;
    localparam int REPORT_CAP  = 100;

    // Index past the last register; writes to it must leave the map unchanged.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef enum int {
        SETUP_DEFAULT,
        SETUP_NARROW,
        SETUP_ANY,
        SETUP_FLAT,
        SETUP_EXTREME
    } t_setup;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    class colormap_checker;
        logic signed [DATA_W-1:0] low_bound;
        logic signed [DATA_W-1:0] high_bound;
        bit                       past_max;
        t_pixel                   pending_pixels[$];
        int                       errors;

        function new();
            low_bound  = RST_LOW;
            high_bound = RST_HIGH;
            past_max   = 1'b1;
            errors     = 0;
        endfunction

        function void apply_config(logic [1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_LOW_BOUND:  low_bound = data;
                CFG_HIGH_BOUND: high_bound = data;
                CFG_PAST_MAX:   past_max = data[0];
                default: ;
            endcase
        endfunction

        function logic [Q_W-1:0] normalized(logic signed [DATA_W-1:0] v);
            longint      num;
            longint      den;
            logic [63:0] mag_num;
            logic [63:0] mag_den;
            logic [63:0] quot;
            num = longint'(v) - longint'(low_bound);
            den = longint'(high_bound) - longint'(low_bound);
            if (den == 0) begin
                return (v >= low_bound) ? C_E12 : '0;
            end
            // A zero distance or one pointing away from the range maps to the bottom color.
            if (num == 0 || ((num < 0) != (den < 0))) begin
                return '0;
            end
            mag_num = (num < 0) ? -num : num;
            mag_den = (den < 0) ? -den : den;
            quot = (mag_num << FRAC_BITS) / mag_den;
            return (quot > 64'(C_E12)) ? C_E12 : quot[Q_W-1:0];
        endfunction

        function logic [7:0] slope_level(logic [Q_W-1:0] delta);
            logic [31:0] prod;
            prod = 32'(delta) * 32'(SLOPE);
            return prod[FRAC_BITS +: 8];
        endfunction

        function t_pixel jet_pixel(logic signed [DATA_W-1:0] v);
            logic [Q_W-1:0] c;
            t_pixel         px;
            c = normalized(v);
            if (c < C_E1) begin
                px = '{LVL_ZERO, LVL_ZERO, slope_level(c + C_E1)};
            end else if (c < C_E3) begin
                px = '{LVL_ZERO, slope_level(c - C_E1), LVL_FULL};
            end else if (c < C_E5) begin
                px = '{slope_level(c - C_E3), LVL_FULL, slope_level(C_E5 - c)};
            end else if (c < C_E7) begin
                px = '{LVL_FULL, slope_level(C_E7 - c), LVL_ZERO};
            end else if (c < C_E8) begin
                px = '{slope_level(C_E9 - c), LVL_ZERO, LVL_ZERO};
            end else if (!past_max) begin
                px = '{LVL_DARK, LVL_ZERO, LVL_ZERO};
            end else if (c < C_E9) begin
                px = '{slope_level(c - C_E7), LVL_ZERO, slope_level(c - C_E8)};
            end else if (c < C_E10) begin
                px = '{LVL_FULL, LVL_ZERO, slope_level(c - C_E8)};
            end else if (c < C_E12) begin
                px = '{LVL_FULL, slope_level(c - C_E10), LVL_FULL};
            end else begin
                px = '{LVL_FULL, LVL_FULL, LVL_FULL};
            end
            return px;
        endfunction

        function void note_sample(logic [DATA_W-1:0] v);
            pending_pixels.push_back(jet_pixel(v));
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void report(string chan, logic [7:0] want, logic [7:0] got);
            errors++;
            // Past the cap a broken block would only flood the log.
            if (errors <= REPORT_CAP) begin
                $display("%0t: %s expected %0d, got %0d", $time, chan, want, got);
            end
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel (%0d, %0d, %0d) arrived with none expected",
                         $time, r, g, b);
                return;
            end
            want = pending_pixels.pop_front();
            if (r !== want.red) begin
                report("red", want.red, r);
            end
            if (g !== want.green) begin
                report("green", want.green, g);
            end
            if (b !== want.blue) begin
                report("blue", want.blue, b);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [DATA_W-1:0] i_sample_value = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [7:0]        o_red;
    logic [7:0]        o_green;
    logic [7:0]        o_blue;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = '0;
    logic [DATA_W-1:0] i_cfg_data = '0;

    colormap_checker pixels;
    bit              quiet = 1'b0;
    int              in_idle_pct = 20;
    int              out_stall_pct = 20;
    int              stall_left = 0;

    value_to_rgb_colormap dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("value_to_rgb_colormap test failed");
        $finish;
    end

    // Output side: check each accepted word, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pixels.check_pixel(o_red, o_green, o_blue);
        end
        if (stall_left == 0 && !quiet && $urandom_range(0, 99) < out_stall_pct) begin
            stall_left = $urandom_range(1, 16);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [DATA_W-1:0] v);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 16);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        pixels.note_sample(v);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pixels.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        pixels.apply_config(idx, data);
    endtask

    // Registers change only with the pipeline empty.
    task automatic set_config(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                              input bit past);
        wait_drained();
        write_reg(CFG_LOW_BOUND, lo);
        write_reg(CFG_HIGH_BOUND, hi);
        write_reg(CFG_PAST_MAX, DATA_W'(past));
        write_reg(CFG_SPARE, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input t_setup setup);
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] v;
        longint            span;
        longint            frac;
        bit                past;
        past = $urandom_range(0, 1);
        case (setup)
            SETUP_DEFAULT: begin
                lo = RST_LOW;
                hi = RST_HIGH;
            end
            SETUP_NARROW: begin
                lo = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                if ($urandom_range(0, 1)) begin
                    hi = lo + $urandom_range(1, 32'h0040_0000);
                end else begin
                    hi = lo - $urandom_range(1, 32'h0040_0000);
                end
            end
            SETUP_ANY: begin
                lo = $urandom;
                hi = $urandom;
            end
            SETUP_FLAT: begin
                lo = $urandom;
                hi = lo;
            end
            default: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
                if ($urandom_range(0, 1)) begin
                    lo = 32'h7FFF_FFFF;
                    hi = 32'h8000_0000;
                end
            end
        endcase
        set_config(lo, hi, past);
        in_idle_pct   = 20 * $urandom_range(0, 2);
        out_stall_pct = 20 * $urandom_range(0, 2);
        span = longint'($signed(hi)) - longint'($signed(lo));
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Mostly aim across the whole ramp and a bit past it, with some raw words.
            if ($urandom_range(0, 4) == 0) begin
                v = $urandom;
            end else begin
                frac = $urandom_range(0, 32'h0001_C000);
                v = DATA_W'(longint'($signed(lo)) + ((span * frac) >>> FRAC_BITS)
                            + longint'($urandom_range(0, 2)) - 1);
            end
            send_sample(v);
        end
    endtask

    initial begin
        logic [DATA_W-1:0] ramp_points[$];
        pixels = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset bounds: every segment edge, both sides of one, saturation and full range.
        ramp_points = '{32'h0000_0000, 32'h0000_0001, 32'h0000_1FFF, 32'h0000_2000,
                        32'h0000_6000, 32'h0000_A000, 32'h0000_E000, 32'h0000_FFFF,
                        32'h0001_0000, 32'h0001_2000, 32'h0001_4000, 32'h0001_7FFF,
                        32'h0001_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        foreach (ramp_points[k]) begin
            send_sample(ramp_points[k]);
        end

        set_config(32'h0000_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0000_FFFF);
        send_sample(32'h0001_0000);
        send_sample(32'h0001_8000);

        // Zero range: the top color from the bound upward, the bottom one below it.
        set_config(32'd5, 32'd5, 1'b1);
        send_sample(32'd4);
        send_sample(32'd5);
        send_sample(32'd6);

        set_config(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                quiet = 1'b1;
            end
            run_phase(t_setup'(p % 5));
        end

        wait_drained();
        if (pixels.errors == 0 && pixels.pending() == 0) begin
            $display("value_to_rgb_colormap test passed");
        end else begin
            $display("value_to_rgb_colormap test failed");
        end
        $finish;
    end

endmodule

@@ value_to_rgb_colormap.f @@
sv/vrc_pkg.sv
sv/value_to_rgb_colormap.sv
sv/vrc_check.sv
dv/value_to_rgb_colormap_tb.sv
